// ----- sv/ezq_pkg.sv -----
// ----------------------------------------------------------------------------
// ezq_pkg: shared constants for the Euler-angle to quaternion converter
// Formats, CORDIC table and widths used by every stage of the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package ezq_pkg;

	// Output component width, Q1.(QUAT_WIDTH-1); legal range 8 to 32.
	localparam int QUAT_WIDTH = 16;

	// Input angle: degrees times 64.
	localparam int ANGLE_W = 16;
	// Number of axes handled side by side (roll, pitch, yaw).
	localparam int AXES = 3;

	// Half angle in units of 2^-16 degree.
	localparam int H_W = 26;
	// CORDIC x and y in Q2.30.
	localparam int XY_W = 34;
	localparam int CORDIC_STEPS = 18;
	// Sine and cosine in Q.18.
	localparam int TRIG_W = 20;
	// Pair product and triple product widths.
	localparam int PAIR_W = 2 * TRIG_W;
	localparam int TRI_W = PAIR_W + TRIG_W;
	// Quaternion component before normalization, Q.30.
	localparam int Q30_W = 33;
	// Magnitude and length width, and sum of squares width.
	localparam int LEN_W = 32;
	localparam int SUM_W = 2 * LEN_W;
	// Divider remainder width.
	localparam int DIV_W = LEN_W + QUAT_WIDTH;

	localparam logic signed [H_W-1:0] DEG90 = H_W'(5898240);
	localparam logic signed [H_W-1:0] DEG180 = H_W'(11796480);
	localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
	localparam logic signed [XY_W-1:0] TRIG_RND = XY_W'(2048);
	localparam logic signed [TRI_W-1:0] Q30_RND = TRI_W'(8388608);

	// Arctangent of 2^-i in units of 2^-16 degree.
	localparam logic signed [H_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
		H_W'(2949120), H_W'(1740967), H_W'(919879), H_W'(466945),
		H_W'(234379), H_W'(117304), H_W'(58666), H_W'(29335),
		H_W'(14668), H_W'(7334), H_W'(3667), H_W'(1833),
		H_W'(917), H_W'(458), H_W'(229), H_W'(115),
		H_W'(57), H_W'(29)
	};

endpackage
`default_nettype wire

// ----- sv/ezq_in_if.sv -----
// ----------------------------------------------------------------------------
// ezq_in_if: angle input channel
// Carries one word of three rotation angles with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface ezq_in_if;
	import ezq_pkg::*;

	logic valid;
	logic ready;
	logic signed [ANGLE_W-1:0] roll_angle;
	logic signed [ANGLE_W-1:0] pitch_angle;
	logic signed [ANGLE_W-1:0] yaw_angle;

	modport source (output valid, output roll_angle, output pitch_angle,
		output yaw_angle, input ready);
	modport sink (input valid, input roll_angle, input pitch_angle,
		input yaw_angle, output ready);
endinterface
`default_nettype wire

// ----- sv/ezq_out_if.sv -----
// ----------------------------------------------------------------------------
// ezq_out_if: quaternion output channel
// Carries one word of four normalized components with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface ezq_out_if;
	import ezq_pkg::*;

	logic valid;
	logic ready;
	logic signed [QUAT_WIDTH-1:0] quat_w;
	logic signed [QUAT_WIDTH-1:0] quat_x;
	logic signed [QUAT_WIDTH-1:0] quat_y;
	logic signed [QUAT_WIDTH-1:0] quat_z;

	modport source (output valid, output quat_w, output quat_x, output quat_y,
		output quat_z, input ready);
	modport sink (input valid, input quat_w, input quat_x, input quat_y,
		input quat_z, output ready);
endinterface
`default_nettype wire

// ----- sv/ezq_trig.sv -----
// ----------------------------------------------------------------------------
// ezq_trig: half-angle sine and cosine for three axes
// Range reduction, an 18-stage pipelined CORDIC per axis and rounding to Q.18.
// ----------------------------------------------------------------------------
`default_nettype none
module ezq_trig (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_vld,
	input  wire logic signed [ezq_pkg::ANGLE_W-1:0] angle [ezq_pkg::AXES],
	output logic out_vld,
	output logic signed [ezq_pkg::TRIG_W-1:0] cos_v [ezq_pkg::AXES],
	output logic signed [ezq_pkg::TRIG_W-1:0] sin_v [ezq_pkg::AXES]
);
	import ezq_pkg::*;

	logic signed [XY_W-1:0] x_s [AXES][CORDIC_STEPS+1];
	logic signed [XY_W-1:0] y_s [AXES][CORDIC_STEPS+1];
	logic signed [H_W-1:0] z_s [AXES][CORDIC_STEPS+1];
	logic neg_s [AXES][CORDIC_STEPS+1];
	logic vld_s [CORDIC_STEPS+2];

	// Valid bits follow the words through every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CORDIC_STEPS + 2; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_vld;
			for (int k = 1; k < CORDIC_STEPS + 2; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	assign out_vld = vld_s[CORDIC_STEPS+1];

	for (genvar a = 0; a < AXES; a++) begin : g_axis
		logic signed [H_W-1:0] half;
		logic signed [XY_W-1:0] xr;
		logic signed [XY_W-1:0] yr;
		logic signed [TRIG_W-1:0] cr;
		logic signed [TRIG_W-1:0] sr;

		// Half angle is angle * 512 in 2^-16 degree units.
		assign half = $signed({{(H_W-ANGLE_W-9){angle[a][ANGLE_W-1]}}, angle[a], 9'b0});

		// Fold the half angle into [-90, +90] degrees; the fold negates both results.
		always_ff @(posedge clk) begin
			if (en) begin
				x_s[a][0] <= CORDIC_GAIN;
				y_s[a][0] <= '0;
				if (half > DEG90) begin
					z_s[a][0] <= half - DEG180;
					neg_s[a][0] <= 1'b1;
				end else if (half < -DEG90) begin
					z_s[a][0] <= half + DEG180;
					neg_s[a][0] <= 1'b1;
				end else begin
					z_s[a][0] <= half;
					neg_s[a][0] <= 1'b0;
				end
			end
		end

		// One micro-rotation per stage.
		for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
			always_ff @(posedge clk) begin
				if (en) begin
					neg_s[a][i+1] <= neg_s[a][i];
					if (!z_s[a][i][H_W-1]) begin
						x_s[a][i+1] <= x_s[a][i] - (y_s[a][i] >>> i);
						y_s[a][i+1] <= y_s[a][i] + (x_s[a][i] >>> i);
						z_s[a][i+1] <= z_s[a][i] - ATAN_TAB[i];
					end else begin
						x_s[a][i+1] <= x_s[a][i] + (y_s[a][i] >>> i);
						y_s[a][i+1] <= y_s[a][i] - (x_s[a][i] >>> i);
						z_s[a][i+1] <= z_s[a][i] + ATAN_TAB[i];
					end
				end
			end
		end

		// Round Q2.30 to Q.18 and undo the fold.
		assign xr = (x_s[a][CORDIC_STEPS] + TRIG_RND) >>> 12;
		assign yr = (y_s[a][CORDIC_STEPS] + TRIG_RND) >>> 12;
		assign cr = TRIG_W'(xr);
		assign sr = TRIG_W'(yr);

		always_ff @(posedge clk) begin
			if (en) begin
				cos_v[a] <= neg_s[a][CORDIC_STEPS] ? -cr : cr;
				sin_v[a] <= neg_s[a][CORDIC_STEPS] ? -sr : sr;
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/ezq_mix.sv -----
// ----------------------------------------------------------------------------
// ezq_mix: quaternion product network
// Forms the four ZYX components from the six trig values in three stages.
// ----------------------------------------------------------------------------
`default_nettype none
module ezq_mix (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_vld,
	input  wire logic signed [ezq_pkg::TRIG_W-1:0] cos_v [ezq_pkg::AXES],
	input  wire logic signed [ezq_pkg::TRIG_W-1:0] sin_v [ezq_pkg::AXES],
	output logic out_vld,
	output logic signed [ezq_pkg::Q30_W-1:0] comp [4]
);
	import ezq_pkg::*;

	logic vld_s1, vld_s2, vld_s3;
	logic signed [PAIR_W-1:0] czcy_s1, szsy_s1, czsy_s1, szcy_s1;
	logic signed [TRIG_W-1:0] cx_s1, sx_s1;
	logic signed [TRI_W-1:0] t_s2 [8];
	logic signed [TRI_W-1:0] sum [4];
	logic signed [TRI_W-1:0] rnd [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign out_vld = vld_s3;

	// Yaw-pitch pair products; roll values ride along.
	always_ff @(posedge clk) begin
		if (en) begin
			czcy_s1 <= PAIR_W'(cos_v[2]) * PAIR_W'(cos_v[1]);
			szsy_s1 <= PAIR_W'(sin_v[2]) * PAIR_W'(sin_v[1]);
			czsy_s1 <= PAIR_W'(cos_v[2]) * PAIR_W'(sin_v[1]);
			szcy_s1 <= PAIR_W'(sin_v[2]) * PAIR_W'(cos_v[1]);
			cx_s1 <= cos_v[0];
			sx_s1 <= sin_v[0];
		end
	end

	// Triple products, exact in Q.54.
	always_ff @(posedge clk) begin
		if (en) begin
			t_s2[0] <= TRI_W'(czcy_s1) * TRI_W'(cx_s1);
			t_s2[1] <= TRI_W'(szsy_s1) * TRI_W'(sx_s1);
			t_s2[2] <= TRI_W'(czcy_s1) * TRI_W'(sx_s1);
			t_s2[3] <= TRI_W'(szsy_s1) * TRI_W'(cx_s1);
			t_s2[4] <= TRI_W'(czsy_s1) * TRI_W'(cx_s1);
			t_s2[5] <= TRI_W'(szcy_s1) * TRI_W'(sx_s1);
			t_s2[6] <= TRI_W'(szcy_s1) * TRI_W'(cx_s1);
			t_s2[7] <= TRI_W'(czsy_s1) * TRI_W'(sx_s1);
		end
	end

	// Combine the pairs and round to Q.30.
	always_comb begin
		sum[0] = t_s2[0] + t_s2[1];
		sum[1] = t_s2[2] - t_s2[3];
		sum[2] = t_s2[4] + t_s2[5];
		sum[3] = t_s2[6] - t_s2[7];
		for (int k = 0; k < 4; k++) begin
			rnd[k] = (sum[k] + Q30_RND) >>> 24;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				comp[k] <= Q30_W'(rnd[k]);
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/ezq_norm.sv -----
// ----------------------------------------------------------------------------
// ezq_norm: quaternion normalizer
// Sum of squares, bit-per-stage square root, bit-per-stage division, saturation.
// ----------------------------------------------------------------------------
`default_nettype none
module ezq_norm (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_vld,
	input  wire logic signed [ezq_pkg::Q30_W-1:0] comp [4],
	output logic out_vld,
	output logic signed [ezq_pkg::QUAT_WIDTH-1:0] quat [4]
);
	import ezq_pkg::*;

	localparam int QW = QUAT_WIDTH;
	localparam logic [QW-1:0] LIM = QW'(1) << (QW - 1);

	// Front stages: magnitude, squares, sum.
	logic vld_s1, vld_s2, vld_s3;
	logic [LEN_W-1:0] mag_s1 [4], mag_s2 [4], mag_s3 [4];
	logic neg_s1 [4], neg_s2 [4], neg_s3 [4];
	logic [SUM_W-1:0] sq_s2 [4];
	logic [SUM_W-1:0] sum_s3;

	// Square root stages.
	logic sq_vld [1:LEN_W];
	logic [SUM_W-1:0] rem_q [LEN_W+1];
	logic [LEN_W-1:0] root_q [LEN_W+1];
	logic [LEN_W-1:0] rmag_q [LEN_W+1][4];
	logic rneg_q [LEN_W+1][4];

	// Division stages.
	logic dv_vld [1:QW];
	logic [DIV_W-1:0] drem_q [QW+1][4];
	logic [QW-1:0] quo_q [QW+1][4];
	logic dneg_q [QW+1][4];
	logic [LEN_W-1:0] len_q [QW+1];

	logic vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			for (int k = 1; k <= LEN_W; k++) begin
				sq_vld[k] <= 1'b0;
			end
			for (int k = 1; k <= QW; k++) begin
				dv_vld[k] <= 1'b0;
			end
			vld_q <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			sq_vld[1] <= vld_s3;
			for (int k = 2; k <= LEN_W; k++) begin
				sq_vld[k] <= sq_vld[k-1];
			end
			dv_vld[1] <= sq_vld[LEN_W];
			for (int k = 2; k <= QW; k++) begin
				dv_vld[k] <= dv_vld[k-1];
			end
			vld_q <= dv_vld[QW];
		end
	end

	assign out_vld = vld_q;

	// Split each component into sign and magnitude.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				neg_s1[k] <= comp[k][Q30_W-1];
				mag_s1[k] <= LEN_W'(comp[k][Q30_W-1] ? -comp[k] : comp[k]);
			end
		end
	end

	// Square each magnitude.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				sq_s2[k] <= SUM_W'(mag_s1[k]) * SUM_W'(mag_s1[k]);
				mag_s2[k] <= mag_s1[k];
				neg_s2[k] <= neg_s1[k];
			end
		end
	end

	// Add the four squares.
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3 <= (sq_s2[0] + sq_s2[1]) + (sq_s2[2] + sq_s2[3]);
			for (int k = 0; k < 4; k++) begin
				mag_s3[k] <= mag_s2[k];
				neg_s3[k] <= neg_s2[k];
			end
		end
	end

	assign rem_q[0] = sum_s3;
	assign root_q[0] = '0;
	for (genvar k = 0; k < 4; k++) begin : g_rin
		assign rmag_q[0][k] = mag_s3[k];
		assign rneg_q[0][k] = neg_s3[k];
	end

	// Integer square root, one result bit per stage from the top.
	for (genvar j = 0; j < LEN_W; j++) begin : g_sqrt
		localparam int B = LEN_W - 1 - j;
		logic [SUM_W+1:0] trial;

		assign trial = ((SUM_W+2)'(root_q[j]) << (B + 1)) | ((SUM_W+2)'(1) << (2 * B));

		always_ff @(posedge clk) begin
			if (en) begin
				if ((SUM_W+2)'(rem_q[j]) >= trial) begin
					rem_q[j+1] <= rem_q[j] - SUM_W'(trial);
					root_q[j+1] <= root_q[j] | (LEN_W'(1) << B);
				end else begin
					rem_q[j+1] <= rem_q[j];
					root_q[j+1] <= root_q[j];
				end
				for (int k = 0; k < 4; k++) begin
					rmag_q[j+1][k] <= rmag_q[j][k];
					rneg_q[j+1][k] <= rneg_q[j][k];
				end
			end
		end
	end

	// Division input: magnitude scaled to the output format, plus half the length.
	assign len_q[0] = root_q[LEN_W];
	for (genvar k = 0; k < 4; k++) begin : g_din
		assign drem_q[0][k] = (DIV_W'(rmag_q[LEN_W][k]) << (QW - 1))
			+ DIV_W'(root_q[LEN_W] >> 1);
		assign quo_q[0][k] = '0;
		assign dneg_q[0][k] = rneg_q[LEN_W][k];
	end

	// Restoring division, one quotient bit per stage from the top.
	for (genvar j = 0; j < QW; j++) begin : g_div
		localparam int B = QW - 1 - j;
		logic [DIV_W-1:0] den;

		assign den = DIV_W'(len_q[j]) << B;

		always_ff @(posedge clk) begin
			if (en) begin
				len_q[j+1] <= len_q[j];
				for (int k = 0; k < 4; k++) begin
					dneg_q[j+1][k] <= dneg_q[j][k];
					if (drem_q[j][k] >= den) begin
						drem_q[j+1][k] <= drem_q[j][k] - den;
						quo_q[j+1][k] <= quo_q[j][k] | (QW'(1) << B);
					end else begin
						drem_q[j+1][k] <= drem_q[j][k];
						quo_q[j+1][k] <= quo_q[j][k];
					end
				end
			end
		end
	end

	// Saturate, apply the sign; a zero length gives the identity.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				if (len_q[QW] == '0) begin
					quat[k] <= (k == 0) ? $signed(LIM - QW'(1)) : '0;
				end else if (dneg_q[QW][k]) begin
					quat[k] <= $signed(-((quo_q[QW][k] > LIM) ? LIM : quo_q[QW][k]));
				end else begin
					quat[k] <= $signed((quo_q[QW][k] > LIM - QW'(1)) ? LIM - QW'(1)
						: quo_q[QW][k]);
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/euler_to_quaternion_zyx.sv -----
// Throughput: one word per cycle unless the output stalls; every stage is a
// register stage of the pipeline.
// The depth is set by the 18-stage CORDIC, the 32-stage square root and the
// QUAT_WIDTH-stage divider. A stall at the output holds every stage in place.
// Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// euler_to_quaternion_zyx: Euler angles to unit quaternion, ZYX order
// Half-angle CORDIC, product network and normalization in one pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module euler_to_quaternion_zyx (
	input  wire logic clk,
	input  wire logic arst_n,
	ezq_in_if.sink angles,
	ezq_out_if.source quat
);
	import ezq_pkg::*;

	logic en;
	logic trig_vld, mix_vld, norm_vld;
	logic signed [ANGLE_W-1:0] angle [AXES];
	logic signed [TRIG_W-1:0] cos_v [AXES];
	logic signed [TRIG_W-1:0] sin_v [AXES];
	logic signed [Q30_W-1:0] comp [4];
	logic signed [QUAT_WIDTH-1:0] q [4];

	// The whole pipeline advances unless a finished word waits at the output.
	assign en = !norm_vld || quat.ready;
	assign angles.ready = en;

	assign angle[0] = angles.roll_angle;
	assign angle[1] = angles.pitch_angle;
	assign angle[2] = angles.yaw_angle;

	ezq_trig u_trig (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(angles.valid), .angle(angle),
		.out_vld(trig_vld), .cos_v(cos_v), .sin_v(sin_v)
	);

	ezq_mix u_mix (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(trig_vld), .cos_v(cos_v), .sin_v(sin_v),
		.out_vld(mix_vld), .comp(comp)
	);

	ezq_norm u_norm (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(mix_vld), .comp(comp),
		.out_vld(norm_vld), .quat(q)
	);

	assign quat.valid = norm_vld;
	assign quat.quat_w = q[0];
	assign quat.quat_x = q[1];
	assign quat.quat_y = q[2];
	assign quat.quat_z = q[3];

endmodule
`default_nettype wire
